### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge outside reset
`define SCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define SCL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/scl_pkg.sv
package scl_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_WS_HI = 8'h0D;

  localparam logic [7:0] SERVO_LETTER_RESET = 8'd115;
  localparam logic [7:0] SERVO_MAX_RESET    = 8'd12;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_LETTER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MAX    = 1'b1;

  localparam int OUT_ARGS     = 4;
  localparam int ARG_OUT_BITS = 32;
  localparam int OUT_BITS     = 2 + 8 + 8 + OUT_ARGS * ARG_OUT_BITS;
  localparam int TDATA_W      = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_SERVO_WRITE = 2'd0,
    ST_BAD_SERVO   = 2'd1,
    ST_UNKNOWN     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef logic signed [ARG_OUT_BITS-1:0] arg_word_t;

  typedef struct packed {
    logic [7:0] servo_letter;
    logic [7:0] servo_max;
  } cfg_t;

  typedef struct packed {
    status_t                    status;
    logic [7:0]                 command_code;
    logic [7:0]                 servo_index;
    arg_word_t [OUT_ARGS-1:0]   args;
  } result_t;

endpackage

### rtl/core/scl_acc.sv
module scl_acc #(
  parameter int VALUE_BITS = 32
) (
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         negative,
  input  logic [3:0]                   digit,
  output logic signed [VALUE_BITS-1:0] value_next
);

  localparam int WIDE = VALUE_BITS + 4;

  logic [VALUE_BITS-1:0] mag;
  logic [WIDE-1:0]       mag_wide;
  logic [WIDE-1:0]       prod;
  logic [WIDE-1:0]       limit;
  logic [VALUE_BITS-1:0] mag_next;

  always_comb begin
    mag      = negative ? (VALUE_BITS'(0) - $unsigned(value)) : $unsigned(value);
    mag_wide = WIDE'(mag);
    // times ten plus digit
    prod     = (mag_wide << 3) + (mag_wide << 1) + WIDE'(digit);
    limit    = negative ? (WIDE'(1) << (VALUE_BITS - 1))
                        : ((WIDE'(1) << (VALUE_BITS - 1)) - WIDE'(1));
    mag_next = (prod > limit) ? limit[VALUE_BITS-1:0] : prod[VALUE_BITS-1:0];
    value_next = negative ? $signed(VALUE_BITS'(0) - mag_next) : $signed(mag_next);
  end

endmodule

### rtl/core/scl_parse.sv
module scl_parse #(
  parameter int FIELD_CHARS = 16,
  parameter int ARG_FIELDS  = 4,
  parameter int VALUE_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  scl_pkg::cfg_t    cfg,
  input  logic             out_free,
  output logic             res_fire,
  output scl_pkg::result_t res
);

  localparam int CH_W   = $clog2(FIELD_CHARS);
  localparam int FNUM_W = $clog2(ARG_FIELDS + 1);
  localparam int AIDX_W = (ARG_FIELDS > 1) ? $clog2(ARG_FIELDS) : 1;
  localparam int CW     = ((VALUE_BITS > 8) ? VALUE_BITS : 8) + 1;

  logic                         byte_valid;
  logic [7:0]                   byte_q;
  logic                         advance;

  logic [7:0]                   cmd_letter, cmd_letter_next;
  logic [FNUM_W-1:0]            field_num, field_num_next;
  logic [CH_W-1:0]              chars, chars_next;
  scl_pkg::phase_t              phase, phase_next;
  logic                         neg, neg_next;
  logic signed [VALUE_BITS-1:0] arg_val      [ARG_FIELDS];
  logic signed [VALUE_BITS-1:0] arg_val_next [ARG_FIELDS];

  logic [AIDX_W-1:0]            k;
  logic signed [VALUE_BITS-1:0] sel_val;
  logic signed [VALUE_BITS-1:0] acc_val;
  logic                         is_digit;
  logic                         is_ws;
  logic                         is_sign;
  logic [VALUE_BITS-1:0]        a1_dec;
  logic                         a1_ok;

  scl_pkg::arg_word_t [scl_pkg::OUT_ARGS-1:0] args_out;

  assign advance  = byte_valid && ((byte_q != scl_pkg::CHAR_CR) || out_free);
  assign in_ready = !byte_valid || advance;
  assign res_fire = byte_valid && (byte_q == scl_pkg::CHAR_CR) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_letter <= '0;
      field_num  <= '0;
      chars      <= '0;
      phase      <= scl_pkg::PH_LEAD;
      neg        <= 1'b0;
      for (int j = 0; j < ARG_FIELDS; j++) begin
        arg_val[j] <= '0;
      end
    end else begin
      cmd_letter <= cmd_letter_next;
      field_num  <= field_num_next;
      chars      <= chars_next;
      phase      <= phase_next;
      neg        <= neg_next;
      for (int j = 0; j < ARG_FIELDS; j++) begin
        arg_val[j] <= arg_val_next[j];
      end
    end
  end

  assign k        = AIDX_W'(field_num - FNUM_W'(1));
  assign is_digit = (byte_q >= scl_pkg::CHAR_ZERO) && (byte_q <= scl_pkg::CHAR_NINE);
  assign is_ws    = (byte_q >= scl_pkg::CHAR_TAB) && (byte_q <= scl_pkg::CHAR_WS_HI);
  assign is_sign  = (byte_q == scl_pkg::CHAR_PLUS) || (byte_q == scl_pkg::CHAR_MINUS);

  always_comb begin
    sel_val = '0;
    for (int j = 0; j < ARG_FIELDS; j++) begin
      if (AIDX_W'(j) == k) begin
        sel_val = arg_val[j];
      end
    end
  end

  scl_acc #(
    .VALUE_BITS(VALUE_BITS)
  ) u_acc (
    .value      (sel_val),
    .negative   (neg),
    .digit      (byte_q[3:0]),
    .value_next (acc_val)
  );

  always_comb begin
    cmd_letter_next = cmd_letter;
    field_num_next  = field_num;
    chars_next      = chars;
    phase_next      = phase;
    neg_next        = neg;
    for (int j = 0; j < ARG_FIELDS; j++) begin
      arg_val_next[j] = arg_val[j];
    end

    if (advance) begin
      if (byte_q == scl_pkg::CHAR_CR) begin
        cmd_letter_next = '0;
        field_num_next  = '0;
        chars_next      = '0;
        phase_next      = scl_pkg::PH_LEAD;
        neg_next        = 1'b0;
        for (int j = 0; j < ARG_FIELDS; j++) begin
          arg_val_next[j] = '0;
        end
      end else if (byte_q == scl_pkg::CHAR_SPACE) begin
        if (field_num < FNUM_W'(ARG_FIELDS)) begin
          field_num_next = field_num + FNUM_W'(1);
        end else begin
          // extra space restarts the last field
          arg_val_next[ARG_FIELDS-1] = '0;
        end
        chars_next = '0;
        phase_next = scl_pkg::PH_LEAD;
        neg_next   = 1'b0;
      end else if (field_num == '0) begin
        cmd_letter_next = byte_q;
      end else if (chars < CH_W'(FIELD_CHARS - 1)) begin
        chars_next = chars + CH_W'(1);
        case (phase)
          scl_pkg::PH_LEAD: begin
            if (is_ws) begin
              phase_next = scl_pkg::PH_LEAD;
            end else if (is_sign) begin
              neg_next   = (byte_q == scl_pkg::CHAR_MINUS);
              phase_next = scl_pkg::PH_DIGITS;
            end else if (!is_digit) begin
              phase_next = scl_pkg::PH_DONE;
            end else begin
              phase_next = scl_pkg::PH_DIGITS;
              for (int j = 0; j < ARG_FIELDS; j++) begin
                if (AIDX_W'(j) == k) begin
                  arg_val_next[j] = acc_val;
                end
              end
            end
          end
          scl_pkg::PH_DIGITS: begin
            if (!is_digit) begin
              phase_next = scl_pkg::PH_DONE;
            end else begin
              for (int j = 0; j < ARG_FIELDS; j++) begin
                if (AIDX_W'(j) == k) begin
                  arg_val_next[j] = acc_val;
                end
              end
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  // line result, taken from the state as it stands at the carriage return
  assign a1_dec = $unsigned(arg_val[0]) - VALUE_BITS'(1);
  assign a1_ok  = !arg_val[0][VALUE_BITS-1] && (arg_val[0] != '0)
                  && (CW'($unsigned(arg_val[0])) <= CW'(cfg.servo_max));

  for (genvar j = 0; j < scl_pkg::OUT_ARGS; j++) begin : g_out
    if (j < ARG_FIELDS) begin : g_used
      assign args_out[j] = scl_pkg::ARG_OUT_BITS'(arg_val[j]);
    end else begin : g_absent
      assign args_out[j] = '0;
    end
  end

  always_comb begin
    res.command_code = cmd_letter;
    res.servo_index  = '0;
    res.args         = args_out;
    if (cmd_letter == cfg.servo_letter) begin
      if (a1_ok) begin
        res.status      = scl_pkg::ST_SERVO_WRITE;
        res.servo_index = a1_dec[7:0];
      end else begin
        res.status = scl_pkg::ST_BAD_SERVO;
      end
    end else begin
      res.status = scl_pkg::ST_UNKNOWN;
    end
  end

endmodule

### rtl/core/serial_command_line_parser.sv
// Serial command line parser. Takes one received byte per word on the s_ side and
// sustains one byte per clock while no carriage return is held; a line ends in
// carriage return, and its result word reaches m_ through the input register, then
// the result register. Back-pressure on m_ holds the next carriage return in the
// input register until the waiting result is taken, stalling s_. The user must write
// the servo letter and highest servo number on cfg_ while idle; it is not enforced.
`include "assert_macros.svh"

module serial_command_line_parser #(
  parameter int FIELD_CHARS = 16,
  parameter int ARG_FIELDS  = 4,
  parameter int VALUE_BITS  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // rx_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status, command_code, servo_index, arg_one, arg_two, arg_three, arg_four, zero pad
  output logic [scl_pkg::TDATA_W-1:0]     m_tdata,
  input  logic                            cfg_wr_en,
  input  logic [scl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  scl_pkg::cfg_t    cfg;
  scl_pkg::result_t res;
  scl_pkg::result_t res_q;
  logic             res_fire;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.servo_letter <= scl_pkg::SERVO_LETTER_RESET;
      cfg.servo_max    <= scl_pkg::SERVO_MAX_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        scl_pkg::CFG_SERVO_LETTER: cfg.servo_letter <= cfg_data;
        scl_pkg::CFG_SERVO_MAX:    cfg.servo_max    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;

  scl_parse #(
    .FIELD_CHARS(FIELD_CHARS),
    .ARG_FIELDS (ARG_FIELDS),
    .VALUE_BITS (VALUE_BITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .cfg      (cfg),
    .out_free (out_free),
    .res_fire (res_fire),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_fire) begin
      res_q <= res;
    end
  end

  assign m_tdata = scl_pkg::TDATA_W'({res_q.args, res_q.servo_index,
                                      res_q.command_code, res_q.status});

  `SCL_ASSERT(a_no_overwrite, (m_tvalid && !m_tready) |-> !res_fire, "result overwritten while waiting")
  `SCL_ASSERT(a_fire_shows, res_fire |=> m_tvalid, "line result not presented")
  `SCL_ASSERT(a_servo_range, (m_tvalid && (res_q.status == scl_pkg::ST_SERVO_WRITE)) |-> (res_q.servo_index < cfg.servo_max), "servo index beyond highest servo")
  `SCL_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result word present after reset")

endmodule

### tb/tb_serial_command_line_parser.sv
module tb_serial_command_line_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import scl_pkg::*;

  localparam int FIELD_CHARS = 16;
  localparam int ARG_FIELDS  = 4;
  localparam int PHASE_BYTES = 360;

  typedef struct {
    status_t    status;
    logic [7:0] code;
    logic [7:0] idx;
    logic [31:0] arg [OUT_ARGS];
  } line_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SERVO_LETTER;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  serial_command_line_parser dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies
  logic [7:0] servo_letter = SERVO_LETTER_RESET;
  logic [7:0] servo_max    = SERVO_MAX_RESET;

  // line parse state
  logic [7:0] line_letter = 8'h00;
  int         field_idx   = 0;
  int         field_chars = 0;
  phase_t     conv_phase  = PH_LEAD;
  bit         conv_neg    = 1'b0;
  longint     arg_val [ARG_FIELDS] = '{default: 0};

  logic [7:0]   tx_q [$];
  line_result_t line_results_q [$];
  int           fail_count = 0;
  int           pushed = 0;

  int tx_gap = 0;
  int stretch_left = 0;
  bit no_idle = 1'b0;
  int rx_stall = 0;
  int stall_draw;

  function automatic void parse_byte(logic [7:0] c);
    line_result_t res;
    longint mag, lim, d;
    bit dig, take;
    int k;
    if (c == CHAR_CR) begin
      res.code = line_letter;
      res.idx = 8'h00;
      if (line_letter == servo_letter) begin
        if (arg_val[0] >= 1 && arg_val[0] <= servo_max) begin
          res.status = ST_SERVO_WRITE;
          res.idx = 8'(arg_val[0] - 1);
        end else begin
          res.status = ST_BAD_SERVO;
        end
      end else begin
        res.status = ST_UNKNOWN;
      end
      for (int j = 0; j < OUT_ARGS; j++)
        res.arg[j] = (j < ARG_FIELDS) ? arg_val[j][31:0] : 32'h0;
      line_results_q.push_back(res);
      line_letter = 8'h00;
      field_idx = 0;
      field_chars = 0;
      conv_phase = PH_LEAD;
      conv_neg = 1'b0;
      for (int j = 0; j < ARG_FIELDS; j++) arg_val[j] = 0;
    end else if (c == CHAR_SPACE) begin
      if (field_idx < ARG_FIELDS) field_idx++;
      else arg_val[ARG_FIELDS-1] = 0;
      field_chars = 0;
      conv_phase = PH_LEAD;
      conv_neg = 1'b0;
    end else if (field_idx == 0) begin
      line_letter = c;
    end else if (field_chars < FIELD_CHARS - 1) begin
      field_chars++;
      k = field_idx - 1;
      dig = (c >= CHAR_ZERO && c <= CHAR_NINE);
      take = 1'b0;
      if (conv_phase == PH_LEAD) begin
        if (c >= CHAR_TAB && c <= CHAR_WS_HI) begin
          // leading whitespace skipped
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          conv_neg = (c == CHAR_MINUS);
          conv_phase = PH_DIGITS;
        end else if (dig) begin
          conv_phase = PH_DIGITS;
          take = 1'b1;
        end else begin
          conv_phase = PH_DONE;
        end
      end else if (conv_phase == PH_DIGITS) begin
        if (dig) take = 1'b1;
        else conv_phase = PH_DONE;
      end
      if (take) begin
        lim = conv_neg ? 64'sd2147483648 : 64'sd2147483647;
        mag = conv_neg ? -arg_val[k] : arg_val[k];
        d = longint'(c) - longint'(CHAR_ZERO);
        if (mag > (lim - d) / 10) mag = lim;
        else mag = mag * 10 + d;
        arg_val[k] = conv_neg ? -mag : mag;
      end
    end
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result(logic [TDATA_W-1:0] w);
    line_result_t e;
    if (line_results_q.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, w);
      fail_count++;
    end else begin
      e = line_results_q.pop_front();
      compare_field("status", 32'(e.status), 32'(w[1:0]));
      compare_field("command_code", 32'(e.code), 32'(w[9:2]));
      compare_field("servo_index", 32'(e.idx), 32'(w[17:10]));
      for (int j = 0; j < OUT_ARGS; j++)
        compare_field($sformatf("arg%0d", j + 1), e.arg[j], w[18 + 32*j +: 32]);
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) parse_byte(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (tx_q.size() != 0) begin
          s_tdata <= tx_q.pop_front();
          s_tvalid <= 1'b1;
          tx_gap <= no_idle ? 0 : $urandom_range(0, 9);
          if (stretch_left == 0) begin
            stretch_left <= $urandom_range(20, 80);
            no_idle <= ($urandom_range(0, 3) == 0);
          end else begin
            stretch_left <= stretch_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (m_tvalid && m_tready) begin
      check_result(m_tdata);
      stall_draw = no_idle ? 0 : $urandom_range(0, 9);
      rx_stall <= stall_draw;
      m_tready <= (stall_draw == 0);
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      m_tready <= (rx_stall == 1);
    end else if (!m_tvalid && !no_idle && $urandom_range(0, 7) == 0) begin
      rx_stall <= $urandom_range(1, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic push_byte(logic [7:0] b);
    tx_q.push_back(b);
    pushed++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] any_field_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CHAR_SPACE || b == CHAR_CR) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic gen_arg(bit first);
    int kind;
    kind = (first && $urandom_range(0, 2) != 0) ? 10 : $urandom_range(0, 9);
    case (kind)
      0, 1: push_text($sformatf("%0d", $urandom_range(0, 360)));
      2: begin
        push_byte(CHAR_PLUS);
        push_text($sformatf("%0d", $urandom_range(0, 99999)));
      end
      3: begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(9, 12)));
        if ($urandom_range(0, 1)) push_byte(CHAR_MINUS);
        push_text($sformatf("%0d", $urandom));
      end
      4: begin
        push_byte(CHAR_MINUS);
        push_text($sformatf("%0d", $urandom));
      end
      5: repeat ($urandom_range(10, 22)) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
      6: case ($urandom_range(0, 3))
        0: push_text("2147483647");
        1: push_text("2147483648");
        2: push_text("-2147483648");
        default: push_text("-2147483649");
      endcase
      7: begin
        push_text($sformatf("%0d", $urandom_range(0, 999)));
        push_byte(any_field_byte());
        push_text($sformatf("%0d", $urandom_range(0, 999)));
      end
      8: repeat ($urandom_range(1, 5)) push_byte(any_field_byte());
      9: ; // empty field
      default: begin
        if ($urandom_range(0, 3) == 0) push_byte(CHAR_PLUS);
        push_text($sformatf("%0d", $urandom_range(0, servo_max + 1)));
      end
    endcase
  endtask

  task automatic gen_line();
    int n_args;
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 9))
        0: ; // no letter
        1: begin
          push_byte(any_field_byte());
          push_byte(servo_letter);
        end
        2, 3: push_byte(any_field_byte());
        default: push_byte(servo_letter);
      endcase
      if ($urandom_range(0, 9) != 0) begin
        n_args = $urandom_range(0, 5);
        push_byte(CHAR_SPACE);
        for (int k = 0; k < n_args; k++) begin
          if (k != 0) push_byte(CHAR_SPACE);
          if ($urandom_range(0, 15) == 0) push_byte(CHAR_SPACE);
          gen_arg(k == 0);
        end
      end
      push_byte(CHAR_CR);
    end
  endtask

  task automatic fill_phase(int n_bytes);
    pushed = 0;
    while (pushed < n_bytes) gen_line();
  endtask

  task automatic settle();
    while (tx_q.size() != 0 || s_tvalid || line_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_SERVO_LETTER) servo_letter = value;
    else servo_max = value;
  endtask

  task automatic set_config(logic [7:0] letter, logic [7:0] max_no);
    write_reg(CFG_SERVO_LETTER, letter);
    write_reg(CFG_SERVO_MAX, max_no);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed lines at reset settings
    push_text("s 12 -7");
    push_byte(CHAR_CR);
    push_text("xs 1 \t+5 3 4 9");
    push_byte(CHAR_CR);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CHAR_CR);
    push_byte(CHAR_CR);
    fill_phase(PHASE_BYTES);
    settle();

    set_config(8'h00, 8'd1);
    fill_phase(PHASE_BYTES);
    settle();

    set_config(8'hFF, 8'd255);
    fill_phase(PHASE_BYTES);
    settle();

    set_config(8'($urandom_range(33, 126)), 8'($urandom_range(1, 255)));
    fill_phase(PHASE_BYTES);
    settle();

    set_config(SERVO_LETTER_RESET, SERVO_MAX_RESET);
    fill_phase(PHASE_BYTES);
    settle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
